[src/integer_square_root_core_macros.svh]
// Assertion macros for the integer square root core.
`ifndef INTEGER_SQUARE_ROOT_CORE_MACROS_SVH
`define INTEGER_SQUARE_ROOT_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, held off during reset.
`define ISQRT_ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("isqrt check failed");
// Fixed-delay implication, held off during reset.
`define ISQRT_ASSERT_DELAY(label, clk, rst_n, a, n, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> ##n (b)) \
        else $error("isqrt latency check failed");
`else
`define ISQRT_ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ISQRT_ASSERT_DELAY(label, clk, rst_n, a, n, b)
`endif
`endif

[src/isqrt_pkg.sv]
// Shared constants and types for the integer square root core.
package isqrt_pkg;

    localparam int IN_WIDTH_DEF    = 64;
    localparam int RADICAND_W      = 64;
    localparam int ROOT_W          = 33;
    // Root digits resolved per pipeline stage.
    localparam int STEPS_PER_STAGE = 4;

    typedef logic [RADICAND_W-1:0] radicand_t;
    typedef logic [ROOT_W-1:0]     root_t;

endpackage

[src/integer_square_root_core.sv]
// Integer square root core: pipelined digit-by-digit restoring square root.
//
// Input: drive radicand and pulse start; an item is taken when start is high
// and busy is low. busy is always low, so an item can enter every cycle.
// Only the low IN_WIDTH bits of radicand take part.
// Output: done pulses for one cycle with root valid in that cycle. The
// receiver cannot stall the core; nothing is held back.
// Pipeline: an item passes through the stage registers and then the output
// register of done and root. Each pipeline stage resolves four root bits with
// four chained subtract-compares, and a final stage applies rounding.
// Throughput is one item per cycle.
// Configuration: cfg_wr_en writes cfg_wr_data into the round-to-nearest bit;
// write only while no item is in flight. 0 gives the floor of the root, 1
// adds one when the final remainder exceeds the floored root.
// Reset: rst_n clears all stage valid bits, done and the rounding bit
// (floor mode). Items in flight at reset are dropped.
`include "integer_square_root_core_macros.svh"

module integer_square_root_core #(
    parameter int IN_WIDTH = isqrt_pkg::IN_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  isqrt_pkg::radicand_t  radicand,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_wr_data,
    output logic                  done,
    output isqrt_pkg::root_t      root
);

    localparam int SPS     = isqrt_pkg::STEPS_PER_STAGE;
    localparam int NSTEPS  = (IN_WIDTH + 1) / 2;
    localparam int NSTAGES = (NSTEPS + SPS - 1) / SPS;
    localparam int RT      = NSTAGES * SPS;     // root bits carried
    localparam int WW      = 2 * RT;            // padded radicand bits
    localparam int RW      = RT + 2;            // remainder bits

    typedef logic [WW-1:0] rad_w_t;
    typedef logic [RW-1:0] rem_w_t;
    typedef logic [RT-1:0] root_w_t;
    typedef logic [RT:0]   root_rnd_t;

    localparam isqrt_pkg::root_t ROOT_MAX = isqrt_pkg::root_t'(1) << NSTEPS;

    logic    stg_vld_reg  [NSTAGES];
    rad_w_t  stg_rad_reg  [NSTAGES];
    rem_w_t  stg_rem_reg  [NSTAGES];
    root_w_t stg_root_reg [NSTAGES];

    logic             round_reg;
    logic             done_reg;
    isqrt_pkg::root_t root_reg;
    isqrt_pkg::root_t root_next;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            round_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            round_reg <= cfg_wr_data;
        end
    end

    for (genvar s = 0; s < NSTAGES; s++)
    begin : g_stage
        logic    vld_in;
        rad_w_t  rad_in;
        rem_w_t  rem_in;
        root_w_t root_in;
        rad_w_t  rad_next;
        rem_w_t  rem_next;
        root_w_t root_next_s;

        if (s == 0)
        begin : g_first
            assign vld_in  = start;
            assign rad_in  = rad_w_t'(radicand[IN_WIDTH-1:0]);
            assign rem_in  = '0;
            assign root_in = '0;
        end
        else
        begin : g_rest
            assign vld_in  = stg_vld_reg[s-1];
            assign rad_in  = stg_rad_reg[s-1];
            assign rem_in  = stg_rem_reg[s-1];
            assign root_in = stg_root_reg[s-1];
        end

        // Bring down the next radicand pair and try (4q + 1) against it.
        always_comb
        begin
            rem_w_t  r;
            rem_w_t  rr;
            rem_w_t  trial;
            root_w_t q;
            rad_w_t  d;
            r = rem_in;
            q = root_in;
            d = rad_in;
            for (int k = 0; k < SPS; k++)
            begin
                rr    = {r[RW-3:0], d[WW-1 -: 2]};
                trial = {q, 2'b01};
                if (rr >= trial)
                begin
                    r = rr - trial;
                    q = {q[RT-2:0], 1'b1};
                end
                else
                begin
                    r = rr;
                    q = {q[RT-2:0], 1'b0};
                end
                d = {d[WW-3:0], 2'b00};
            end
            rem_next    = r;
            root_next_s = q;
            rad_next    = d;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                stg_vld_reg[s] <= 1'b0;
            end
            else
            begin
                stg_vld_reg[s] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            stg_rad_reg[s]  <= rad_next;
            stg_rem_reg[s]  <= rem_next;
            stg_root_reg[s] <= root_next_s;
        end
    end

    // Remainder above the floored root means the fraction is at least one half.
    always_comb
    begin
        root_rnd_t rnd;
        rnd = root_rnd_t'(stg_root_reg[NSTAGES-1]);
        if (round_reg && (stg_rem_reg[NSTAGES-1] > rem_w_t'(stg_root_reg[NSTAGES-1])))
        begin
            rnd = rnd + root_rnd_t'(1);
        end
        root_next = isqrt_pkg::root_t'(rnd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= stg_vld_reg[NSTAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

    `ISQRT_ASSERT_DELAY(a_item_reaches_output, clk, rst_n, stg_vld_reg[0], NSTAGES, done)
    `ISQRT_ASSERT_IMPLIES(a_root_in_range, clk, rst_n, done, root <= ROOT_MAX)
    `ISQRT_ASSERT_IMPLIES(a_floor_below_max, clk, rst_n, done && !$past(round_reg), root < ROOT_MAX)

endmodule

[verif/integer_square_root_core_tb.sv]
// Testbench for the integer square root core: queued stimulus, self-checking root monitor.
module integer_square_root_core_tb;

    localparam int RADICAND_BITS = isqrt_pkg::IN_WIDTH_DEF;
    localparam int LATENCY       = 9;
    localparam int TAIL_CYCLES   = 4 * LATENCY;
    localparam int RUN_LIMIT     = 2_000_000;
    localparam int PHASE_ITEMS   = 150;

    typedef enum logic [1:0] {
        OP_ITEM,
        OP_CFG,
        OP_DRAIN
    } op_kind_t;

    typedef struct {
        op_kind_t             kind;
        isqrt_pkg::radicand_t value;
        logic                 mode;
        int unsigned          idle_pct;
    } stim_op_t;

    logic                 clk;
    logic                 rst_n       = 1'b0;
    logic                 start       = 1'b0;
    isqrt_pkg::radicand_t radicand    = '0;
    logic                 cfg_wr_en   = 1'b0;
    logic                 cfg_wr_data = 1'b0;
    logic                 busy;
    logic                 done;
    isqrt_pkg::root_t     root;

    stim_op_t         stim_ops[$];
    isqrt_pkg::root_t roots_due[$];
    logic             round_mode = 1'b0;
    int unsigned      errors     = 0;

    integer_square_root_core #(
        .IN_WIDTH(RADICAND_BITS)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .radicand   (radicand),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .done       (done),
        .root       (root)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Restoring digit-by-digit square root, one root bit per pass.
    function automatic isqrt_pkg::root_t digit_sqrt(isqrt_pkg::radicand_t value, logic rounded);
        logic [63:0] rest;
        logic [63:0] partial;
        logic [63:0] weight;
        logic [63:0] probe;
        rest    = value & ({64{1'b1}} >> (64 - RADICAND_BITS));
        partial = '0;
        weight  = 64'h1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            probe = partial + weight;
            if (rest >= probe)
            begin
                rest    = rest - probe;
                partial = probe + weight;
            end
            partial = partial >> 1;
            weight  = weight >> 2;
        end
        if (rounded && rest > partial)
            partial = partial + 1;
        return partial[isqrt_pkg::ROOT_W-1:0];
    endfunction

    task automatic add_item(isqrt_pkg::radicand_t value, int unsigned idle_pct);
        stim_op_t op;
        op.kind     = OP_ITEM;
        op.value    = value;
        op.mode     = 1'b0;
        op.idle_pct = idle_pct;
        stim_ops.push_back(op);
    endtask

    task automatic add_wait(op_kind_t kind, logic mode);
        stim_op_t op;
        op.kind     = kind;
        op.value    = '0;
        op.mode     = mode;
        op.idle_pct = 0;
        stim_ops.push_back(op);
    endtask

    // Mix of full-range values, squares and their rounding neighbors, and short values.
    task automatic add_random_phase(int unsigned count, int unsigned idle_pct);
        logic [63:0]          base;
        logic [63:0]          square;
        isqrt_pkg::radicand_t value;
        for (int unsigned n = 0; n < count; n++)
        begin
            case ($urandom_range(3))
                0: value = {$urandom, $urandom};
                1:
                begin
                    base = {32'h0, $urandom};
                    if ($urandom_range(7) == 0)
                        base = 64'hFFFF_FFFF - 64'($urandom_range(3));
                    square = base * base;
                    case ($urandom_range(4))
                        0: value = square - 1;
                        1: value = square;
                        2: value = square + 1;
                        3: value = square + base;
                        default: value = square + base + 1;
                    endcase
                end
                2: value = {$urandom, $urandom} >> $urandom_range(63);
                default: value = 64'($urandom_range(300));
            endcase
            add_item(value, idle_pct);
            if ($urandom_range(63) == 0)
                add_wait(OP_DRAIN, 1'b0);
        end
    endtask

    // Driver: presents the next queued op; config writes and pauses wait for an empty pipe.
    always @(posedge clk)
    begin : drive_ops
        logic                 next_start;
        logic                 next_wr;
        logic                 next_wr_data;
        isqrt_pkg::radicand_t next_value;
        next_start   = start && busy;
        next_value   = next_start ? radicand : {$urandom, $urandom};
        next_wr      = 1'b0;
        next_wr_data = 1'($urandom_range(1));
        if (!rst_n)
            next_start = 1'b0;
        else
        begin
            if (start && !busy)
                roots_due.push_back(digit_sqrt(radicand, round_mode));
            if (!next_start && stim_ops.size() > 0)
            begin
                case (stim_ops[0].kind)
                    OP_ITEM:
                        if ($urandom_range(99) >= stim_ops[0].idle_pct)
                        begin
                            next_start = 1'b1;
                            next_value = stim_ops[0].value;
                            void'(stim_ops.pop_front());
                        end
                    OP_CFG:
                        if (roots_due.size() == 0)
                        begin
                            next_wr      = 1'b1;
                            next_wr_data = stim_ops[0].mode;
                            round_mode   = stim_ops[0].mode;
                            void'(stim_ops.pop_front());
                        end
                    default:
                        if (roots_due.size() == 0)
                            void'(stim_ops.pop_front());
                endcase
            end
        end
        start       <= next_start;
        radicand    <= next_value;
        cfg_wr_en   <= next_wr;
        cfg_wr_data <= next_wr_data;
    end

    always @(posedge clk)
    begin : check_roots
        isqrt_pkg::root_t want;
        if (rst_n && done === 1'b1)
        begin
            if (roots_due.size() == 0)
            begin
                $error("root: result with no item outstanding, actual %0d", root);
                errors++;
            end
            else
            begin
                want = roots_due.pop_front();
                if (root !== want)
                begin
                    $error("root: expected %0d, actual %0d", want, root);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("FAIL integer_square_root_core");
        $finish;
    end

    initial
    begin : main_seq
        isqrt_pkg::radicand_t edge_values[13];
        edge_values = '{
            64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd6, 64'd7,
            64'hFFFF_FFFF_FFFF_FFFF,
            64'hFFFF_FFFE_0000_0001,   // (2^32-1)^2
            64'hFFFF_FFFF_0000_0000,   // just below the round-up point
            64'hFFFF_FFFF_0000_0001,   // rounds up to 2^32
            64'h8000_0000_0000_0000,
            64'hAAAA_AAAA_AAAA_AAAA
        };

        // Directed: floor mode out of reset, then rounding.
        foreach (edge_values[i])
            add_item(edge_values[i], 16);
        add_wait(OP_CFG, 1'b1);
        foreach (edge_values[i])
            add_item(edge_values[i], 16);
        add_wait(OP_DRAIN, 1'b0);

        add_random_phase(PHASE_ITEMS, 16);
        add_wait(OP_CFG, 1'b0);
        add_random_phase(PHASE_ITEMS, 16);
        add_wait(OP_CFG, 1'b1);
        add_random_phase(PHASE_ITEMS, 73);
        add_wait(OP_CFG, 1'b0);
        add_random_phase(PHASE_ITEMS, 73);
        add_wait(OP_CFG, 1'b1);
        add_random_phase(PHASE_ITEMS, 0);
        add_wait(OP_CFG, 1'b0);
        add_random_phase(PHASE_ITEMS, 0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (stim_ops.size() > 0 || start || cfg_wr_en || roots_due.size() > 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (errors == 0)
            $display("PASS integer_square_root_core");
        else
            $display("FAIL integer_square_root_core");
        $finish;
    end
endmodule
